/* src/assert_macros.svh */
// Assertion macros shared by the chart RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication property checked on every rising edge outside reset.
`define RAC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression that must never be true outside reset.
`define RAC_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define RAC_ASSERT(lbl, clk, rstn, prop, msg)
`define RAC_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* src/rac_pkg.sv */
// Shared types and constants of the risk-adjusted CUSUM chart.
package rac_pkg;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int SQR_ITERS = 24;

  // register indexes
  localparam logic [2:0] REG_RA        = 3'd0;
  localparam logic [2:0] REG_LOG_RA    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_W_FAIL    = 3'd3;
  localparam logic [2:0] REG_W_SUCC    = 3'd4;
  localparam logic [2:0] REG_RISK_ADJ  = 3'd5;
  localparam logic [2:0] REG_MODE      = 3'd6;
  localparam logic [2:0] REG_WARMUP    = 3'd7;

  // chart modes
  localparam logic [1:0] MODE_CONDITIONAL = 2'd1;
  localparam logic [1:0] MODE_CYCLICAL    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_SQR, ST_MUL, ST_RND, ST_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic mant_load;
    logic sqr_step;
    logic mul;
    logic rnd;
    logic upd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic log_in;
    logic norm_done;
    logic sqr_last;
    logic out_free;
  } ctrl_sts_t;
endpackage

/* src/rac_ctrl.sv */
// Controller state machine sequencing one item through the datapath.
module rac_ctrl import rac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);
  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.log_in ? ST_NORM : ST_UPD;
        end
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          cmd.mant_load = 1'b1;
          state_nxt     = ST_SQR;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SQR: begin
        cmd.sqr_step = 1'b1;
        if (sts.sqr_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `include "assert_macros.svh"
  `RAC_ASSERT(a_one_cmd, clk, rst_n, $onehot0(cmd), "more than one datapath command")
  `RAC_ASSERT(a_upd_idle, clk, rst_n, cmd.upd |=> !in_stall, "not idle after update")
  `RAC_ASSERT(a_load_stall, clk, rst_n, cmd.load |=> in_stall, "item taken while busy")
endmodule

/* src/rac_datapath.sv */
// Datapath: configuration, iterative fixed-point log, score and count update.
module rac_datapath import rac_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [19:0]  cfg_data,
  input  logic         in_action,
  input  logic [15:0]  in_risk,
  input  logic         in_outcome,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [19:0]  out_score,
  output logic [16:0]  out_weight,
  output logic [23:0]  out_run_length,
  output logic         out_alarm,
  output logic         out_in_warmup,
  input  ctrl_cmd_t    cmd,
  output ctrl_sts_t    sts
);
  localparam int AW   = ((FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32) + 1;
  localparam int EW   = $clog2(AW);
  localparam int LGI  = EW + 2;
  localparam int LGW  = LGI + 24;
  localparam int PRW  = LGW + 30;
  localparam int SH   = 54 - FRAC_BITS;
  localparam int FW   = PRW + 2;
  localparam int CW   = COUNT_WIDTH;
  localparam int XW   = (CW > 24) ? CW : 24;

  // configuration registers
  logic [15:0] ra_r, wu_r;
  logic signed [15:0] log_ra_r, wf_r, ws_r;
  logic [19:0] thr_r;
  logic        radj_r;
  logic [1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_r <= 16'd8192; log_ra_r <= 16'sd2839; thr_r <= 20'd18432;
      wf_r <= '0; ws_r <= '0; radj_r <= 1'b1; mode_r <= '0; wu_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RA:        ra_r     <= cfg_data[15:0];
        REG_LOG_RA:    log_ra_r <= $signed(cfg_data[15:0]);
        REG_THRESHOLD: thr_r    <= cfg_data;
        REG_W_FAIL:    wf_r     <= $signed(cfg_data[15:0]);
        REG_W_SUCC:    ws_r     <= $signed(cfg_data[15:0]);
        REG_RISK_ADJ:  radj_r   <= cfg_data[0];
        REG_MODE:      mode_r   <= cfg_data[1:0];
        REG_WARMUP:    wu_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic        action_r, outcome_r, neg_r;
  logic [AW-1:0] norm_r;
  logic [EW-1:0] e_r;
  logic [30:0] m_r;
  logic [23:0] frac_r;
  logic [4:0]  it_r;
  logic [PRW-1:0] prod_r;
  logic signed [16:0] w_r;
  logic [19:0] score_r;
  logic [CW-1:0] count_r;
  logic        alarm_r;
  logic        out_valid_r;
  logic [19:0] out_score_r;
  logic [16:0] out_weight_r;
  logic [23:0] out_run_r;
  logic        out_alarm_r, out_warm_r;

  // log argument 2^F*(65536-p) + ra*p
  logic [16:0] risk_comp;
  logic [31:0] ra_p;
  logic [AW-1:0] arg;
  assign risk_comp = 17'h10000 - {1'b0, in_risk};
  assign ra_p      = ra_r * in_risk;
  assign arg       = (AW'(risk_comp) << FRAC_BITS) + AW'(ra_p);

  // squaring step
  logic [61:0] sq;
  logic [31:0] sq_hi;
  assign sq    = m_r * m_r;
  assign sq_hi = sq[61:30];

  // log2 to magnitude
  logic signed [LGI-1:0] lg_int;
  logic signed [LGW-1:0] lg;
  logic [LGW-1:0] lg_mag;
  assign lg_int = $signed({2'b00, e_r}) - LGI'(FRAC_BITS + 16);
  assign lg     = {lg_int, frac_r};
  assign lg_mag = lg[LGW-1] ? LGW'(-lg) : LGW'(lg);

  // rounding and weight
  logic [PRW:0] rsum, rmag;
  logic signed [FW-1:0] lnv, lra, wfull;
  logic signed [16:0] w_log, w_plain;
  assign rsum  = {1'b0, prod_r} + ((PRW + 1)'(1) << (SH - 1));
  assign rmag  = rsum >> SH;
  assign lnv   = neg_r ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  assign lra   = outcome_r ? FW'(log_ra_r) : '0;
  assign wfull = lra - lnv;
  always_comb begin
    if (wfull < $signed(FW'(-65536)))     w_log = 17'sh10000;
    else if (wfull > $signed(FW'(65535))) w_log = 17'sh0FFFF;
    else                                  w_log = wfull[16:0];
  end
  assign w_plain = in_outcome ? 17'(wf_r) : 17'(ws_r);

  // score, count and alarm update
  logic signed [21:0] ssum;
  logic [19:0] s_clamp, score_new;
  logic [CW-1:0] cnt_inc, cnt_new;
  logic alarm_new, warm, warm_new;
  logic [CW-1:0] run_full;
  logic [XW-1:0] run_x;
  logic [23:0] run_sat;
  assign ssum    = $signed({2'b00, score_r}) + 22'(w_r);
  assign s_clamp = ssum[21] ? 20'd0 : (ssum[20] ? 20'hFFFFF : ssum[19:0]);
  assign cnt_inc = (&count_r) ? count_r : count_r + 1'b1;
  assign warm    = cnt_inc <= CW'(wu_r);
  always_comb begin
    score_new = score_r;
    cnt_new   = count_r;
    alarm_new = alarm_r;
    if (action_r) begin
      score_new = '0;
      cnt_new   = '0;
      alarm_new = 1'b0;
    end else if (!alarm_r) begin
      score_new = s_clamp;
      cnt_new   = cnt_inc;
      if (s_clamp > thr_r) begin
        if (mode_r == MODE_CONDITIONAL && warm) begin
          score_new = '0;
          cnt_new   = '0;
        end else if (mode_r == MODE_CYCLICAL && warm) begin
          score_new = '0;
        end else begin
          alarm_new = 1'b1;
        end
      end
    end
  end
  assign warm_new = cnt_new <= CW'(wu_r);
  assign run_full = ((mode_r == MODE_CONDITIONAL || mode_r == MODE_CYCLICAL)) ?
                    (warm_new ? '0 : cnt_new - CW'(wu_r)) : cnt_new;
  assign run_x    = XW'(run_full);
  assign run_sat  = (run_x > XW'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(run_x);

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r  <= in_action;
      outcome_r <= in_outcome;
      norm_r    <= arg;
      e_r       <= EW'(AW - 1);
      w_r       <= in_action ? '0 : w_plain;
    end
    if (cmd.norm_step) begin
      norm_r <= norm_r << 1;
      e_r    <= e_r - 1'b1;
    end
    if (cmd.mant_load) begin
      m_r    <= norm_r[AW-1 -: 31];
      frac_r <= '0;
      it_r   <= 5'(SQR_ITERS - 1);
    end
    if (cmd.sqr_step) begin
      it_r <= it_r - 1'b1;
      if (sq_hi[31]) begin
        m_r          <= sq_hi[31:1];
        frac_r[it_r] <= 1'b1;
      end else begin
        m_r <= sq_hi[30:0];
      end
    end
    if (cmd.mul) begin
      neg_r  <= lg[LGW-1];
      prod_r <= PRW'(lg_mag * LN2_Q30);
    end
    if (cmd.rnd) w_r <= w_log;
    if (cmd.upd) begin
      out_score_r  <= score_new;
      out_weight_r <= w_r;
      out_run_r    <= run_sat;
      out_alarm_r  <= alarm_new;
      out_warm_r   <= warm_new;
    end
  end

  // control state of the chart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r     <= '0;
      count_r     <= '0;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        score_r <= score_new;
        count_r <= cnt_new;
        alarm_r <= alarm_new;
      end
      if (cmd.upd)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign sts.log_in    = radj_r && !in_action;
  assign sts.norm_done = norm_r[AW-1];
  assign sts.sqr_last  = (it_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_score      = out_score_r;
  assign out_weight     = out_weight_r;
  assign out_run_length = out_run_r;
  assign out_alarm      = out_alarm_r;
  assign out_in_warmup  = out_warm_r;

  `include "assert_macros.svh"
  `RAC_NEVER(a_norm_zero, clk, rst_n, cmd.norm_step && norm_r == '0, "log argument is zero")
  `RAC_NEVER(a_mant_norm, clk, rst_n, cmd.sqr_step && !m_r[30], "mantissa not normalized")
  `RAC_ASSERT(a_alarm_hold, clk, rst_n, !cmd.upd |=> $stable(alarm_r),
              "alarm changed without update")
endmodule

/* src/risk_adjusted_cusum_chart.sv */
// Restart and plain-mode items go from load straight to the update state; with the
// log, normalize shifts one bit a cycle, then 24 squaring steps of the mantissa,
// a multiply by ln 2 and rounding precede the update. Items are taken one at a time.
// The result register lets the next item start while a result waits.
// Reset (rst_n low, synchronous) clears score, count, alarm and loads the
// register defaults.
module risk_adjusted_cusum_chart import rac_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_risk,
  input  logic        in_outcome,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_score,
  output logic [16:0] out_weight,
  output logic [23:0] out_run_length,
  output logic        out_alarm,
  output logic        out_in_warmup
);
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rac_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  rac_datapath #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_action(in_action), .in_risk(in_risk), .in_outcome(in_outcome),
    .out_stall(out_stall), .out_valid(out_valid),
    .out_score(out_score), .out_weight(out_weight),
    .out_run_length(out_run_length), .out_alarm(out_alarm),
    .out_in_warmup(out_in_warmup),
    .cmd(cmd), .sts(sts)
  );
endmodule

/* test/risk_adjusted_cusum_chart_test.sv */
// Testbench for the risk-adjusted CUSUM chart: predicts each result and checks it.
`timescale 1ns / 1ps
module risk_adjusted_cusum_chart_test import rac_pkg::*;;

  localparam int SCORE_TOP = 20'hFFFFF;
  localparam int RUN_TOP   = 24'hFFFFFF;
  localparam longint COUNT_TOP = (64'd1 << 24) - 1;

  typedef struct packed {
    logic [19:0] score;
    logic [16:0] weight;
    logic [23:0] run_length;
    logic        alarm;
    logic        in_warmup;
  } chart_result_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;
  logic in_valid, in_stall, in_action, in_outcome;
  logic [15:0] in_risk;
  logic out_valid, out_stall;
  logic [19:0] out_score;
  logic [16:0] out_weight;
  logic [23:0] out_run_length;
  logic out_alarm, out_in_warmup;

  // predictor copy of configuration and state
  longint ra_q, log_ra_q, thresh_q, w_fail_q, w_succ_q, risk_adj_q, mode_q, warmup_q;
  longint score_q, count_q, alarm_q;

  chart_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int alarms_seen = 0;
  int out_wait = 0;
  bit stall_enable = 1;

  risk_adjusted_cusum_chart u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  // ln(x / 2^28) rounded to Q.12, via log2 by repeated squaring
  function automatic longint log_q12(longint unsigned x);
    int e;
    longint unsigned m, mag, r;
    longint lg, prod;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    lg = longint'(e - 28) * (longint'(1) << 24);
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        lg += longint'(1) << i;
      end
    end
    prod = lg * 744261118;
    mag = prod < 0 ? longint'(-prod) : prod;
    r = (mag + (64'd1 << 41)) >> 42;
    return prod < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic chart_result_t predict_chart(bit act, logic [15:0] risk, bit outc);
    chart_result_t res;
    longint w, s, run;
    longint unsigned arg;
    bit warm;
    w = 0;
    if (act) begin
      score_q = 0; count_q = 0; alarm_q = 0;
    end else begin
      if (risk_adj_q != 0) begin
        arg = (64'd4096 * (65536 - risk)) + longint'(ra_q) * risk;
        w = (outc ? log_ra_q : 0) - log_q12(arg);
      end else begin
        w = outc ? w_fail_q : w_succ_q;
      end
      if (w < -65536) w = -65536;
      if (w > 65535) w = 65535;
      if (alarm_q == 0) begin
        s = score_q + w;
        if (s < 0) s = 0;
        if (s > SCORE_TOP) s = SCORE_TOP;
        score_q = s;
        if (count_q < COUNT_TOP) count_q++;
        if (score_q > thresh_q) begin
          warm = count_q <= warmup_q;
          if (mode_q == MODE_CONDITIONAL && warm) begin
            score_q = 0; count_q = 0;
          end else if (mode_q == MODE_CYCLICAL && warm) begin
            score_q = 0;
          end else begin
            alarm_q = 1;
          end
        end
      end
    end
    if (mode_q == MODE_CONDITIONAL || mode_q == MODE_CYCLICAL)
      run = count_q > warmup_q ? count_q - warmup_q : 0;
    else
      run = count_q;
    if (run > RUN_TOP) run = RUN_TOP;
    res.score = score_q[19:0];
    res.weight = w[16:0];
    res.run_length = run[23:0];
    res.alarm = alarm_q[0];
    res.in_warmup = count_q <= warmup_q;
    return res;
  endfunction

  // result checker; out_stall is drawn at random between results
  always @(posedge clk) begin
    chart_result_t got, exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_score, out_weight, out_run_length, out_alarm, out_in_warmup};
        results_seen++;
        if (out_alarm) alarms_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got.score !== exp_res.score) begin
            $display("%0t: score exp %h got %h", $time, exp_res.score, got.score);
            errors++;
          end
          if (got.weight !== exp_res.weight) begin
            $display("%0t: weight exp %h got %h", $time, exp_res.weight, got.weight);
            errors++;
          end
          if (got.run_length !== exp_res.run_length) begin
            $display("%0t: run_length exp %h got %h", $time, exp_res.run_length,
                     got.run_length);
            errors++;
          end
          if (got.alarm !== exp_res.alarm) begin
            $display("%0t: alarm exp %b got %b", $time, exp_res.alarm, got.alarm);
            errors++;
          end
          if (got.in_warmup !== exp_res.in_warmup) begin
            $display("%0t: in_warmup exp %b got %b", $time, exp_res.in_warmup,
                     got.in_warmup);
            errors++;
          end
        end
        out_wait = stall_enable ? $urandom_range(0, 9) : 0;
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  // valid stays up after an accept until the next item or an idle gap
  task automatic send_item(bit act, logic [15:0] risk, bit outc, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_action <= act; in_risk <= risk; in_outcome <= outc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_chart(act, risk, outc));
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= value[19:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      REG_RA:        ra_q = value & 16'hFFFF;
      REG_LOG_RA:    log_ra_q = longint'($signed(value[15:0]));
      REG_THRESHOLD: thresh_q = value & 20'hFFFFF;
      REG_W_FAIL:    w_fail_q = longint'($signed(value[15:0]));
      REG_W_SUCC:    w_succ_q = longint'($signed(value[15:0]));
      REG_RISK_ADJ:  risk_adj_q = value & 1;
      REG_MODE:      mode_q = value & 3;
      REG_WARMUP:    warmup_q = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic send_random(int n, int fail_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 2)
        send_item(1'b1, 16'($urandom), 1'($urandom));
      else
        send_item(1'b0, 16'($urandom), $urandom_range(0, 99) < fail_pct);
    end
  endtask

  // directed: risk and field extremes, restart, alarm latching at defaults
  task automatic test_directed();
    send_item(1'b0, 16'h0000, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'h0000, 1'b1);
    send_item(1'b0, 16'hFFFF, 1'b0);
    send_item(1'b0, 16'h8000, 1'b1);
    send_item(1'b0, 16'h0001, 1'b1, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++) send_item(1'b0, 16'h0100, 1'b1);
    send_item(1'b0, 16'h4000, 1'b1);
    send_item(1'b1, 16'h0000, 1'b0);
    drain();
  endtask

  // odds ratio extremes in risk-adjusted mode
  task automatic test_ra_extremes();
    write_reg(REG_RA, 1);
    write_reg(REG_LOG_RA, -32768);
    send_item(1'b1, 16'd0, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'hFFFF, 1'b0);
    drain();
    write_reg(REG_RA, 65535);
    write_reg(REG_LOG_RA, 32767);
    write_reg(REG_THRESHOLD, 20'hFFFFF);
    for (int i = 0; i < 40; i++) send_item(1'b0, 16'($urandom_range(0, 2000)), 1'b1);
    send_item(1'b0, 16'hFFFF, 1'b0);
    drain();
  endtask

  // fixed weights, saturation of the score and negative floor
  task automatic test_plain_weights();
    write_reg(REG_RISK_ADJ, 0);
    write_reg(REG_W_FAIL, 32767);
    write_reg(REG_W_SUCC, -32768);
    send_item(1'b1, 16'd0, 1'b0);
    for (int i = 0; i < 40; i++) send_item(1'b0, 16'($urandom), 1'b1);
    send_item(1'b0, 16'($urandom), 1'b0);
    drain();
    write_reg(REG_THRESHOLD, 0);
    send_item(1'b0, 16'd0, 1'b1);
    send_item(1'b0, 16'd0, 1'b0);
    drain();
    write_reg(REG_RISK_ADJ, 1);
  endtask

  // warm-up behavior for each chart mode, including undefined mode 3
  task automatic test_modes();
    for (int md = 0; md < 4; md++) begin
      write_reg(REG_MODE, md);
      write_reg(REG_WARMUP, md == 3 ? 65535 : $urandom_range(3, 30));
      write_reg(REG_THRESHOLD, $urandom_range(2000, 20000));
      write_reg(REG_RA, $urandom_range(4096, 20000));
      write_reg(REG_LOG_RA, $urandom_range(0, 8000));
      send_item(1'b1, 16'd0, 1'b0);
      send_random(240, 40);
      drain();
    end
  endtask

  // random configuration phases with random traffic
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      stall_enable = ph != 3;
      write_reg(REG_RA, $urandom_range(1, 65535));
      write_reg(REG_LOG_RA, $urandom_range(0, 65535));
      write_reg(REG_THRESHOLD, $urandom_range(0, 1) ? $urandom_range(0, 40000)
                                                    : $urandom_range(0, 1048575));
      write_reg(REG_W_FAIL, $urandom_range(0, 65535));
      write_reg(REG_W_SUCC, $urandom_range(0, 65535));
      write_reg(REG_RISK_ADJ, $urandom_range(0, 1));
      write_reg(REG_MODE, $urandom_range(0, 3));
      write_reg(REG_WARMUP, $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom);
      send_random(40, $urandom_range(10, 90));
      drain();
    end
    stall_enable = 1;
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_action = 0; in_risk = '0; in_outcome = 0; out_stall = 0;
    ra_q = 8192; log_ra_q = 2839; thresh_q = 18432; w_fail_q = 0; w_succ_q = 0;
    risk_adj_q = 1; mode_q = 0; warmup_q = 0;
    score_q = 0; count_q = 0; alarm_q = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_ra_extremes();
    test_plain_weights();
    test_modes();
    test_random_phases();
    drain();
    $display("Sent %0d items, checked %0d results (%0d with alarm set)",
             items_sent, results_seen, alarms_seen);
    $display("Covered all chart modes, both weight sources and register extremes");
    if (errors == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
